>>> rtl/core/tpqc_pkg.sv
// tpqc_pkg: shared widths, register indexes, event codes and divider
// request/response types for the touch press qualifier and calibrator
// no dependencies
package tpqc_pkg;

  localparam int RawW    = 10;
  localparam int ScrW    = 16;
  localparam int PresW   = 12;
  localparam int EvW     = 2;
  localparam int CountW  = 3;
  localparam int RegIdxW = 3;
  localparam int CfgW    = 16;

  // divider operand widths: |dv| * |dscreen| < 2^26, |span| <= 1023
  localparam int DvdW  = 26;
  localparam int DvsW  = 10;
  localparam int QuotW = 16;

  localparam logic [PresW-1:0] PressLow  = 12'd100;
  localparam logic [PresW-1:0] PressHigh = 12'd1000;

  localparam logic [RegIdxW-1:0] RegRawLeft      = 3'd0;
  localparam logic [RegIdxW-1:0] RegRawRight     = 3'd1;
  localparam logic [RegIdxW-1:0] RegRawTop       = 3'd2;
  localparam logic [RegIdxW-1:0] RegRawBottom    = 3'd3;
  localparam logic [RegIdxW-1:0] RegScreenLeft   = 3'd4;
  localparam logic [RegIdxW-1:0] RegScreenRight  = 3'd5;
  localparam logic [RegIdxW-1:0] RegScreenTop    = 3'd6;
  localparam logic [RegIdxW-1:0] RegScreenBottom = 3'd7;

  localparam logic [EvW-1:0] EvNone    = 2'd0;
  localparam logic [EvW-1:0] EvPress   = 2'd1;
  localparam logic [EvW-1:0] EvHold    = 2'd2;
  localparam logic [EvW-1:0] EvRelease = 2'd3;

  typedef struct packed {
    logic            start;
    logic [DvdW-1:0] dividend;
    logic [DvsW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [QuotW-1:0] quot;
  } div_rsp_t;

endpackage

>>> rtl/core/tpqc_if.sv
// tpqc_if: valid/ready channel interfaces for raw samples and touch events
// depends on tpqc_pkg
interface tpqc_in_if;
  logic                        valid;
  logic                        ready;
  logic [tpqc_pkg::RawW-1:0]   sample_x;
  logic [tpqc_pkg::RawW-1:0]   sample_y;
  logic [tpqc_pkg::PresW-1:0]  sample_pressure;

  modport source (output valid, sample_x, sample_y, sample_pressure, input ready);
  modport sink (input valid, sample_x, sample_y, sample_pressure, output ready);
endinterface

interface tpqc_out_if;
  logic                       valid;
  logic                       ready;
  logic [tpqc_pkg::EvW-1:0]   event_res;
  logic [tpqc_pkg::ScrW-1:0]  screen_x;
  logic [tpqc_pkg::ScrW-1:0]  screen_y;

  modport source (output valid, event_res, screen_x, screen_y, input ready);
  modport sink (input valid, event_res, screen_x, screen_y, output ready);
endinterface

>>> rtl/core/tpqc_div.sv
// tpqc_div: restoring unsigned divider, one quotient bit per cycle,
// keeps the low quotient bits only; depends on tpqc_pkg
module tpqc_div (
  input  logic               clk,
  input  logic               rst,
  input  tpqc_pkg::div_req_t req,
  output tpqc_pkg::div_rsp_t rsp
);

  localparam int CntW = $clog2(tpqc_pkg::DvdW);

  logic                          busy;
  logic                          done;
  logic [CntW-1:0]               cnt;
  logic [tpqc_pkg::DvdW-1:0]     dvd;
  logic [tpqc_pkg::DvsW-1:0]     dvs;
  logic [tpqc_pkg::DvsW:0]       rem;
  logic [tpqc_pkg::QuotW-1:0]    quot;

  logic [tpqc_pkg::DvsW:0]       rem_sh;
  logic                          fits;
  logic [tpqc_pkg::DvsW:0]       rem_next;

  always_comb begin
    rem_sh   = {rem[tpqc_pkg::DvsW-1:0], dvd[tpqc_pkg::DvdW-1]};
    fits     = rem_sh >= {1'b0, dvs};
    rem_next = fits ? rem_sh - {1'b0, dvs} : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= CntW'(tpqc_pkg::DvdW - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      dvd  <= req.dividend;
      dvs  <= req.divisor;
      rem  <= '0;
      quot <= '0;
    end else if (busy) begin
      dvd  <= {dvd[tpqc_pkg::DvdW-2:0], 1'b0};
      rem  <= rem_next;
      quot <= {quot[tpqc_pkg::QuotW-2:0], fits};
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = quot;

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("divider done without a preceding busy pass");

  a_last_step_done: assert property (@(posedge clk) disable iff (rst)
    busy && cnt == '0 |=> done)
    else $error("divider missed done after last step");

endmodule

>>> rtl/core/touch_press_qualifier_calibrator.sv
// touch_press_qualifier_calibrator: touch qualification counter, event
// logic and two-axis linear calibration over one shared divider
// depends on tpqc_pkg, tpqc_if, tpqc_div
//
//  channel   dir  word                                          handshake
//  samples   in   sample_x, sample_y, sample_pressure           valid/ready
//  results   out  event_res, screen_x, screen_y                 valid/ready
//  wr_*      in   wr_index, wr_data (register write)            wr_en only
//
// a sample that does not trigger a mapping goes straight from idle to the finish state
// a mapping sample runs, per axis and x then y, a multiply step and then
// the shared restoring divider (one bit step per dividend bit, then done);
// a zero span skips the divider for that axis
// a sample is taken only in idle; the result register lets the next sample
// start while the previous word still waits on results.ready
// rst is synchronous and restores the calibration defaults
module touch_press_qualifier_calibrator #(
  parameter int SAMPLE_COUNT = 5
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [tpqc_pkg::RegIdxW-1:0]   wr_index,
  input  logic [tpqc_pkg::CfgW-1:0]      wr_data,
  tpqc_in_if.sink                        samples,
  tpqc_out_if.source                     results
);

  localparam logic [tpqc_pkg::CountW-1:0] CountTop = tpqc_pkg::CountW'(SAMPLE_COUNT);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMul  = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StFin  = 2'd3;

  logic [1:0] state;
  logic       axis;

  logic [tpqc_pkg::RawW-1:0] raw_left, raw_right, raw_top, raw_bottom;
  logic [tpqc_pkg::ScrW-1:0] screen_left, screen_right, screen_top, screen_bottom;

  logic [tpqc_pkg::CountW-1:0] press_count;
  logic                        holding;
  logic [tpqc_pkg::ScrW-1:0]   mapped_x, mapped_y;
  logic [tpqc_pkg::EvW-1:0]    ev;
  logic [tpqc_pkg::RawW-1:0]   sx, sy;
  logic                        neg;
  logic [tpqc_pkg::ScrW-1:0]   lo_q;

  logic                        out_valid;
  logic [tpqc_pkg::EvW-1:0]    out_ev;
  logic [tpqc_pkg::ScrW-1:0]   out_x, out_y;
  logic                        out_load;

  logic                        accept;
  logic                        touched;
  logic [tpqc_pkg::CountW-1:0] press_count_next;
  logic                        press;
  logic                        held;
  logic                        holding_next;
  logic [tpqc_pkg::EvW-1:0]    ev_next;

  logic [tpqc_pkg::RawW-1:0]   v, in_lo, in_hi;
  logic [tpqc_pkg::ScrW-1:0]   out_lo, out_hi;
  logic [tpqc_pkg::RawW:0]     d_in, d_in_neg, span, span_neg;
  logic [tpqc_pkg::ScrW:0]     d_out, d_out_neg;
  logic [tpqc_pkg::RawW-1:0]   d_in_mag;
  logic [tpqc_pkg::DvsW-1:0]   span_mag;
  logic [tpqc_pkg::ScrW-1:0]   d_out_mag;
  logic [tpqc_pkg::DvdW-1:0]   prod;
  logic [tpqc_pkg::ScrW-1:0]   q_signed, map_res;

  tpqc_pkg::div_req_t div_req;
  tpqc_pkg::div_rsp_t div_rsp;

  assign accept = samples.valid && samples.ready;
  assign samples.ready = state == StIdle;
  assign out_load = state == StFin && (!out_valid || results.ready);

  // qualification counter and event decision
  always_comb begin
    touched = samples.sample_pressure > tpqc_pkg::PressLow &&
              samples.sample_pressure < tpqc_pkg::PressHigh;
    press_count_next = press_count;
    if (touched) begin
      if (press_count < CountTop) press_count_next = press_count + 1'b1;
    end else if (press_count != '0) begin
      press_count_next = press_count - 1'b1;
    end
    press        = press_count_next == CountTop && !holding;
    held         = holding || press;
    holding_next = held;
    ev_next      = tpqc_pkg::EvNone;
    if (held) begin
      if (press_count_next == '0) begin
        holding_next = 1'b0;
        ev_next      = tpqc_pkg::EvRelease;
      end else if (press_count_next == CountTop) begin
        ev_next = press ? tpqc_pkg::EvPress : tpqc_pkg::EvHold;
      end
    end
  end

  // axis operands: raw y to screen x first, then raw x to screen y
  always_comb begin
    v         = axis ? sx : sy;
    in_lo     = axis ? raw_top : raw_left;
    in_hi     = axis ? raw_bottom : raw_right;
    out_lo    = axis ? screen_top : screen_left;
    out_hi    = axis ? screen_bottom : screen_right;
    d_in      = {1'b0, v} - {1'b0, in_lo};
    span      = {1'b0, in_hi} - {1'b0, in_lo};
    d_out     = {1'b0, out_hi} - {1'b0, out_lo};
    d_in_neg  = -d_in;
    span_neg  = -span;
    d_out_neg = -d_out;
    d_in_mag  = d_in[tpqc_pkg::RawW] ? d_in_neg[tpqc_pkg::RawW-1:0] : d_in[tpqc_pkg::RawW-1:0];
    span_mag  = span[tpqc_pkg::RawW] ? span_neg[tpqc_pkg::DvsW-1:0] : span[tpqc_pkg::DvsW-1:0];
    d_out_mag = d_out[tpqc_pkg::ScrW] ? d_out_neg[tpqc_pkg::ScrW-1:0]
                                      : d_out[tpqc_pkg::ScrW-1:0];
    prod      = tpqc_pkg::DvdW'(d_in_mag) * tpqc_pkg::DvdW'(d_out_mag);
    q_signed  = neg ? tpqc_pkg::ScrW'(-div_rsp.quot) : div_rsp.quot;
    map_res   = q_signed + lo_q;
  end

  assign div_req.start    = state == StMul && span != '0;
  assign div_req.dividend = prod;
  assign div_req.divisor  = span_mag;

  tpqc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_left      <= 10'd0;
      raw_right     <= 10'd1023;
      raw_top       <= 10'd0;
      raw_bottom    <= 10'd1023;
      screen_left   <= 16'd0;
      screen_right  <= 16'd319;
      screen_top    <= 16'd0;
      screen_bottom <= 16'd239;
    end else if (wr_en) begin
      unique case (wr_index)
        tpqc_pkg::RegRawLeft:      raw_left      <= wr_data[tpqc_pkg::RawW-1:0];
        tpqc_pkg::RegRawRight:     raw_right     <= wr_data[tpqc_pkg::RawW-1:0];
        tpqc_pkg::RegRawTop:       raw_top       <= wr_data[tpqc_pkg::RawW-1:0];
        tpqc_pkg::RegRawBottom:    raw_bottom    <= wr_data[tpqc_pkg::RawW-1:0];
        tpqc_pkg::RegScreenLeft:   screen_left   <= wr_data;
        tpqc_pkg::RegScreenRight:  screen_right  <= wr_data;
        tpqc_pkg::RegScreenTop:    screen_top    <= wr_data;
        tpqc_pkg::RegScreenBottom: screen_bottom <= wr_data;
        default: ;
      endcase
    end
  end

  // sequencer and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= StIdle;
      axis        <= 1'b0;
      press_count <= '0;
      holding     <= 1'b0;
      mapped_x    <= '0;
      mapped_y    <= '0;
      ev          <= tpqc_pkg::EvNone;
      out_valid   <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (results.ready) out_valid <= 1'b0;
      unique case (state)
        StIdle: begin
          if (accept) begin
            press_count <= press_count_next;
            holding     <= holding_next;
            ev          <= ev_next;
            axis        <= 1'b0;
            state       <= (touched && press_count_next == CountTop) ? StMul : StFin;
          end
        end
        StMul: begin
          if (span == '0) begin
            // zero span gives the low screen value
            if (axis) mapped_y <= out_lo;
            else      mapped_x <= out_lo;
            axis  <= 1'b1;
            state <= axis ? StFin : StMul;
          end else begin
            state <= StDiv;
          end
        end
        StDiv: begin
          if (div_rsp.done) begin
            if (axis) mapped_y <= map_res;
            else      mapped_x <= map_res;
            axis  <= 1'b1;
            state <= axis ? StFin : StMul;
          end
        end
        StFin: begin
          if (out_load) state <= StIdle;
        end
        default: state <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sx <= samples.sample_x;
      sy <= samples.sample_y;
    end
    if (state == StMul) begin
      neg  <= d_in[tpqc_pkg::RawW] ^ d_out[tpqc_pkg::ScrW] ^ span[tpqc_pkg::RawW];
      lo_q <= out_lo;
    end
    if (out_load) begin
      out_ev <= ev;
      out_x  <= mapped_x;
      out_y  <= mapped_y;
    end
  end

  assign results.valid     = out_valid;
  assign results.event_res = out_ev;
  assign results.screen_x  = out_x;
  assign results.screen_y  = out_y;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    press_count <= CountTop)
    else $error("press counter above its top");

  a_event_count: assert property (@(posedge clk) disable iff (rst)
    (ev == tpqc_pkg::EvPress || ev == tpqc_pkg::EvHold) |-> press_count == CountTop && holding)
    else $error("press or hold event without a full counter");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != StIdle)
    else $error("sequencer stayed idle after taking a sample");

  a_div_only_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.busy |-> state == StDiv)
    else $error("divider running outside the divide step");

endmodule

>>> tb/tb_touch_press_qualifier_calibrator.sv
// tb_touch_press_qualifier_calibrator: self-checking bench for the touch qualifier and
// calibrator, directed table then random touch/release bursts over several calibrations
// depends on tpqc_pkg, tpqc_if and the touch_press_qualifier_calibrator rtl
`timescale 1ns / 1ps

module tb_touch_press_qualifier_calibrator;
  import tpqc_pkg::*;

  localparam int SampleCount   = 5;
  localparam int WatchdogLimit = 4000;
  localparam int PhaseCount    = 9;
  localparam int PhaseItems    = 100;
  localparam int DirCount      = 28;

  typedef struct packed {
    logic [EvW-1:0]  ev;
    logic [ScrW-1:0] sx;
    logic [ScrW-1:0] sy;
  } touch_word_t;

  typedef enum logic {RowSample, RowWrite} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [RegIdxW-1:0] idx;
    logic [CfgW-1:0]    data;
    logic [RawW-1:0]    x;
    logic [RawW-1:0]    y;
    logic [PresW-1:0]   p;
    logic               known;
    touch_word_t        want;
  } dir_row_t;

  // counter climbs to the top, press, hold, decays to release, then a zero x span
  localparam dir_row_t DirRows [DirCount] = '{
    '{RowSample, '0, '0, 10'd0, 10'd0, 12'd0, 1'b1, '{EvNone, 16'd0, 16'd0}},
    '{RowSample, '0, '0, 10'd1023, 10'd1023, 12'd100, 1'b1, '{EvNone, 16'd0, 16'd0}},
    '{RowSample, '0, '0, 10'd0, 10'd1023, 12'd1000, 1'b1, '{EvNone, 16'd0, 16'd0}},
    '{RowSample, '0, '0, 10'd1023, 10'd0, 12'd4095, 1'b1, '{EvNone, 16'd0, 16'd0}},
    '{RowSample, '0, '0, 10'd1023, 10'd1023, 12'd101, 1'b1, '{EvNone, 16'd0, 16'd0}},
    '{RowSample, '0, '0, 10'd0, 10'd0, 12'd999, 1'b1, '{EvNone, 16'd0, 16'd0}},
    '{RowSample, '0, '0, 10'd341, 10'd682, 12'd500, 1'b1, '{EvNone, 16'd0, 16'd0}},
    '{RowSample, '0, '0, 10'd682, 10'd341, 12'd640, 1'b1, '{EvNone, 16'd0, 16'd0}},
    '{RowSample, '0, '0, 10'd1023, 10'd1023, 12'd500, 1'b1, '{EvPress, 16'd319, 16'd239}},
    '{RowSample, '0, '0, 10'd0, 10'd0, 12'd999, 1'b1, '{EvHold, 16'd0, 16'd0}},
    '{RowSample, '0, '0, 10'd512, 10'd512, 12'd0, 1'b1, '{EvNone, 16'd0, 16'd0}},
    '{RowSample, '0, '0, 10'd512, 10'd512, 12'd4095, 1'b1, '{EvNone, 16'd0, 16'd0}},
    '{RowSample, '0, '0, 10'd0, 10'd1023, 12'd100, 1'b1, '{EvNone, 16'd0, 16'd0}},
    '{RowSample, '0, '0, 10'd1023, 10'd0, 12'd1000, 1'b1, '{EvNone, 16'd0, 16'd0}},
    '{RowSample, '0, '0, 10'd0, 10'd0, 12'd3000, 1'b1, '{EvRelease, 16'd0, 16'd0}},
    '{RowSample, '0, '0, 10'd0, 10'd0, 12'd50, 1'b1, '{EvNone, 16'd0, 16'd0}},
    // upper bits of raw registers must be dropped
    '{RowWrite, RegRawLeft, 16'hFDF4, '0, '0, '0, 1'b0, '0},
    '{RowWrite, RegRawRight, 16'h01F4, '0, '0, '0, 1'b0, '0},
    '{RowWrite, RegScreenLeft, 16'hFFFF, '0, '0, '0, 1'b0, '0},
    '{RowWrite, RegScreenTop, 16'd1000, '0, '0, '0, 1'b0, '0},
    '{RowWrite, RegScreenBottom, 16'd0, '0, '0, '0, 1'b0, '0},
    '{RowSample, '0, '0, 10'd512, 10'd77, 12'd300, 1'b1, '{EvNone, 16'd0, 16'd0}},
    '{RowSample, '0, '0, 10'd512, 10'd77, 12'd300, 1'b1, '{EvNone, 16'd0, 16'd0}},
    '{RowSample, '0, '0, 10'd512, 10'd77, 12'd300, 1'b1, '{EvNone, 16'd0, 16'd0}},
    '{RowSample, '0, '0, 10'd512, 10'd77, 12'd300, 1'b1, '{EvNone, 16'd0, 16'd0}},
    '{RowSample, '0, '0, 10'd512, 10'd77, 12'd300, 1'b0, '0},
    '{RowSample, '0, '0, 10'd1023, 10'd1023, 12'd700, 1'b0, '0},
    '{RowSample, '0, '0, 10'd0, 10'd0, 12'd700, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst;
  logic wr_en;
  logic [RegIdxW-1:0] wr_index;
  logic [CfgW-1:0]    wr_data;

  tpqc_in_if  sample_ch ();
  tpqc_out_if result_ch ();

  touch_press_qualifier_calibrator #(
    .SAMPLE_COUNT (SampleCount)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .samples  (sample_ch),
    .results  (result_ch)
  );

  // calibration and qualifier state as the block should hold it
  logic [CfgW-1:0] cal_reg [8];
  int              qual_count;
  logic            is_held;
  logic [ScrW-1:0] cal_x;
  logic [ScrW-1:0] cal_y;

  touch_word_t pending_words [$];
  touch_word_t exp_word;
  int          err_count;
  int          idle_pct;
  int          stall_cycles;

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what);
    err_count++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  function automatic logic [ScrW-1:0] cal_map(input logic [RawW-1:0] v, in_lo, in_hi,
                                              input logic [ScrW-1:0] out_lo, out_hi);
    longint span;
    longint num;
    longint r;
    span = longint'(in_hi) - longint'(in_lo);
    if (span == 0) begin
      r = longint'(out_lo);
    end else begin
      num = (longint'(v) - longint'(in_lo)) * (longint'(out_hi) - longint'(out_lo));
      r = num / span + longint'(out_lo);
    end
    return r[ScrW-1:0];
  endfunction

  function automatic touch_word_t predict_touch(input logic [RawW-1:0] x, y,
                                                input logic [PresW-1:0] p);
    touch_word_t w;
    logic fresh;
    fresh = 1'b0;
    if (p > PressLow && p < PressHigh) begin
      if (qual_count < SampleCount) qual_count++;
      if (qual_count == SampleCount) begin
        // raw y drives screen x, raw x drives screen y
        cal_x = cal_map(y, cal_reg[RegRawLeft][RawW-1:0], cal_reg[RegRawRight][RawW-1:0],
                        cal_reg[RegScreenLeft], cal_reg[RegScreenRight]);
        cal_y = cal_map(x, cal_reg[RegRawTop][RawW-1:0], cal_reg[RegRawBottom][RawW-1:0],
                        cal_reg[RegScreenTop], cal_reg[RegScreenBottom]);
      end
    end else if (qual_count > 0) begin
      qual_count--;
    end
    if (qual_count == SampleCount && !is_held) begin
      is_held = 1'b1;
      fresh = 1'b1;
    end
    w.ev = EvNone;
    if (is_held) begin
      if (qual_count == 0) begin
        is_held = 1'b0;
        w.ev = EvRelease;
      end else if (qual_count == SampleCount) begin
        w.ev = fresh ? EvPress : EvHold;
      end
    end
    w.sx = cal_x;
    w.sy = cal_y;
    return w;
  endfunction

  task automatic send_sample(input logic [RawW-1:0] x, y, input logic [PresW-1:0] p,
                             input logic known, input touch_word_t want);
    touch_word_t w;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sample_ch.valid           <= 1'b1;
    sample_ch.sample_x        <= x;
    sample_ch.sample_y        <= y;
    sample_ch.sample_pressure <= p;
    do @(posedge clk); while (!sample_ch.ready);
    w = predict_touch(x, y, p);
    pending_words.push_back(known ? want : w);
  endtask

  task automatic drain_words();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [CfgW-1:0] data);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(negedge clk);
    wr_en    <= 1'b0;
    cal_reg[idx] = (idx <= RegRawBottom) ? (data & 16'h03FF) : data;
  endtask

  function automatic logic [RawW-1:0] rand_raw();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return RawW'($urandom_range(1023));
    endcase
  endfunction

  function automatic logic [PresW-1:0] touch_pressure();
    case ($urandom_range(9))
      0: return 12'd101;
      1: return 12'd999;
      default: return PresW'($urandom_range(999, 101));
    endcase
  endfunction

  function automatic logic [PresW-1:0] lift_pressure();
    case ($urandom_range(9))
      0: return 12'd100;
      1: return 12'd1000;
      2: return 12'd4095;
      3: return 12'd0;
      4, 5, 6: return PresW'($urandom_range(100));
      default: return PresW'($urandom_range(4095, 1000));
    endcase
  endfunction

  task automatic load_phase_config(input int ph);
    logic [CfgW-1:0] vals [8];
    case (ph)
      0: begin
        vals[RegRawLeft]      = 16'd0;
        vals[RegRawRight]     = 16'd1023;
        vals[RegRawTop]       = 16'd0;
        vals[RegRawBottom]    = 16'd1023;
        vals[RegScreenLeft]   = 16'd0;
        vals[RegScreenRight]  = 16'd319;
        vals[RegScreenTop]    = 16'd0;
        vals[RegScreenBottom] = 16'd239;
      end
      1: begin
        // reversed x, one-count y span, full screen range
        vals[RegRawLeft]      = 16'hFFFF;
        vals[RegRawRight]     = 16'hFC00;
        vals[RegRawTop]       = 16'd0;
        vals[RegRawBottom]    = 16'd1;
        vals[RegScreenLeft]   = 16'd0;
        vals[RegScreenRight]  = 16'hFFFF;
        vals[RegScreenTop]    = 16'hFFFF;
        vals[RegScreenBottom] = 16'd0;
      end
      2: begin
        vals[RegRawLeft]      = 16'd0;
        vals[RegRawRight]     = 16'd1023;
        vals[RegRawTop]       = 16'd1023;
        vals[RegRawBottom]    = 16'd0;
        vals[RegScreenLeft]   = 16'hFFFF;
        vals[RegScreenRight]  = 16'd0;
        vals[RegScreenTop]    = 16'd0;
        vals[RegScreenBottom] = 16'hFFFF;
      end
      default: begin
        for (int r = 0; r < 8; r++) begin
          if (r <= int'(RegRawBottom)) begin
            vals[r] = {6'($urandom_range(63)), rand_raw()};
          end else begin
            case ($urandom_range(4))
              0: vals[r] = '0;
              1: vals[r] = '1;
              default: vals[r] = CfgW'($urandom_range(65535));
            endcase
          end
        end
        // zero spans now and then
        if ($urandom_range(3) == 0)
          vals[RegRawRight] = {6'($urandom_range(63)), vals[RegRawLeft][RawW-1:0]};
        if ($urandom_range(3) == 0)
          vals[RegRawBottom] = {6'($urandom_range(63)), vals[RegRawTop][RawW-1:0]};
      end
    endcase
    for (int r = 0; r < 8; r++) write_reg(RegIdxW'(r), vals[r]);
  endtask

  always @(negedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_words.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        exp_word = pending_words.pop_front();
        if (result_ch.event_res !== exp_word.ev)
          report_mismatch($sformatf("event_res got %0d want %0d",
                                    result_ch.event_res, exp_word.ev));
        if (result_ch.screen_x !== exp_word.sx)
          report_mismatch($sformatf("screen_x got %0d want %0d",
                                    result_ch.screen_x, exp_word.sx));
        if (result_ch.screen_y !== exp_word.sy)
          report_mismatch($sformatf("screen_y got %0d want %0d",
                                    result_ch.screen_y, exp_word.sy));
      end
    end
  end

  // cycles without any word moving on either channel
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WatchdogLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int sent;
    int n;
    int m;
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    sample_ch.valid = 1'b0;
    sample_ch.sample_x = '0;
    sample_ch.sample_y = '0;
    sample_ch.sample_pressure = '0;
    idle_pct = 24;
    cal_reg[RegRawLeft]      = 16'd0;
    cal_reg[RegRawRight]     = 16'd1023;
    cal_reg[RegRawTop]       = 16'd0;
    cal_reg[RegRawBottom]    = 16'd1023;
    cal_reg[RegScreenLeft]   = 16'd0;
    cal_reg[RegScreenRight]  = 16'd319;
    cal_reg[RegScreenTop]    = 16'd0;
    cal_reg[RegScreenBottom] = 16'd239;
    qual_count = 0;
    is_held = 1'b0;
    cal_x = '0;
    cal_y = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DirCount; i++) begin
      if (DirRows[i].kind == RowWrite) begin
        drain_words();
        write_reg(DirRows[i].idx, DirRows[i].data);
      end else begin
        send_sample(DirRows[i].x, DirRows[i].y, DirRows[i].p, DirRows[i].known,
                    DirRows[i].want);
      end
    end

    for (int ph = 0; ph < PhaseCount; ph++) begin
      drain_words();
      load_phase_config(ph);
      idle_pct = (ph == 4) ? 0 : 24;
      sent = 0;
      while (sent < PhaseItems) begin
        if ($urandom_range(9) < 8) begin
          // finger down for a while, then lifted
          n = $urandom_range(9, 1);
          m = $urandom_range(7, 1);
          repeat (n) send_sample(rand_raw(), rand_raw(), touch_pressure(), 1'b0, '0);
          repeat (m) send_sample(rand_raw(), rand_raw(), lift_pressure(), 1'b0, '0);
          sent += n + m;
        end else begin
          n = $urandom_range(6, 1);
          repeat (n) send_sample(rand_raw(), rand_raw(), PresW'($urandom_range(4095)),
                                 1'b0, '0);
          sent += n;
        end
      end
    end

    drain_words();
    repeat (80) @(posedge clk);
    if (err_count == 0 && pending_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
